// ===== src/csvt_pkg.sv =====
// Shared types and constants for the CSV stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        QM_UNQUOTED = 2'd0,
        QM_QUOTED   = 2'd1,
        QM_SEEN     = 2'd2
    } t_quote_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ===== src/csvt_if.sv =====
// Handshake channel interfaces for the tokenizer input and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] in_byte;

    modport source (output valid, output cmd, output in_byte, input ready);
    modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== src/csv_stream_tokenizer.sv =====
// Top level of the streaming CSV tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// CSV stream tokenizer. Each input beat carries either one text byte (cmd 0)
// or an end-of-text command (cmd 1). Each beat yields zero, one or two result
// beats: content bytes (kind 0), field ends (kind 1) and row-closing field
// ends (kind 2); last marks the final result of an input beat. Double quotes
// open and close quoting and never appear in the output; a doubled quote
// inside quotes becomes one literal quote; commas and newlines inside quotes
// are content. A carriage return is held back one byte and dropped if an
// unquoted newline follows. End of text closes any pending field and row and
// returns to the reset state. The tokenizer state updates in the same cycle
// the beat is taken and its results land in a two-entry result register, so
// an input beat is taken every cycle while the consumer keeps up; a beat that
// produces two results holds the input while the second result drains.
// Results appear in the cycle after the input beat is taken.
module csv_stream_tokenizer (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    csvt_in_if.sink      i_in,
    csvt_out_if.source   o_out
);
    import csvt_pkg::*;

    // Tokenizer state
    t_quote_mode r_qm;
    logic        r_held;
    logic        r_fhc;
    logic        r_rhf;
    t_quote_mode n_qm;
    logic        n_held;
    logic        n_fhc;
    logic        n_rhf;

    // Result register: two slots, a pending count and the slot being shown
    t_result     r_res [2];
    logic [1:0]  r_cnt;
    logic        r_sel;

    // Results of the beat being taken
    t_kind       v_kind [2];
    logic [7:0]  v_byte [2];
    logic [1:0]  v_cnt;
    logic        v_quoted;
    logic        v_done;

    logic        in_fire;
    logic        out_fire;

    assign out_fire = o_out.valid && o_out.ready;
    // Take a new beat only once the result register empties this cycle.
    assign i_in.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        n_qm     = r_qm;
        n_held   = r_held;
        n_fhc    = r_fhc;
        n_rhf    = r_rhf;
        v_kind[0] = KIND_BYTE;
        v_kind[1] = KIND_BYTE;
        v_byte[0] = 8'h00;
        v_byte[1] = 8'h00;
        v_cnt    = 2'd0;
        v_quoted = (r_qm == QM_QUOTED);
        v_done   = 1'b0;

        if (i_in.cmd == CMD_END) begin
            // Close a pending field/row, then return to reset state.
            if (r_fhc || r_rhf) begin
                if (r_held) begin
                    v_kind[v_cnt[0]] = KIND_BYTE;
                    v_byte[v_cnt[0]] = CH_CR;
                    v_cnt = v_cnt + 2'd1;
                end
                v_kind[v_cnt[0]] = KIND_ROW;
                v_byte[v_cnt[0]] = 8'h00;
                v_cnt = v_cnt + 2'd1;
            end
            n_qm   = QM_UNQUOTED;
            n_held = 1'b0;
            n_fhc  = 1'b0;
            n_rhf  = 1'b0;
        end else begin
            if (r_qm == QM_SEEN) begin
                if (i_in.in_byte == CH_QUOTE) begin
                    // Doubled quote: emit one literal quote, stay quoted.
                    if (r_held) begin
                        v_kind[v_cnt[0]] = KIND_BYTE;
                        v_byte[v_cnt[0]] = CH_CR;
                        v_cnt = v_cnt + 2'd1;
                    end
                    v_kind[v_cnt[0]] = KIND_BYTE;
                    v_byte[v_cnt[0]] = CH_QUOTE;
                    v_cnt  = v_cnt + 2'd1;
                    n_held = 1'b0;
                    n_fhc  = 1'b1;
                    n_qm   = QM_QUOTED;
                    v_done = 1'b1;
                end else begin
                    v_quoted = 1'b0;
                end
            end

            if (!v_done) begin
                if (v_quoted && (i_in.in_byte == CH_QUOTE)) begin
                    n_qm = QM_SEEN;
                end else if (!v_quoted && (i_in.in_byte == CH_QUOTE)) begin
                    n_qm = QM_QUOTED;
                end else if (!v_quoted && (i_in.in_byte == CH_COMMA)) begin
                    n_qm = QM_UNQUOTED;
                    if (r_held) begin
                        v_kind[v_cnt[0]] = KIND_BYTE;
                        v_byte[v_cnt[0]] = CH_CR;
                        v_cnt = v_cnt + 2'd1;
                    end
                    v_kind[v_cnt[0]] = KIND_FIELD;
                    v_byte[v_cnt[0]] = 8'h00;
                    v_cnt  = v_cnt + 2'd1;
                    n_held = 1'b0;
                    n_fhc  = 1'b0;
                    n_rhf  = 1'b1;
                end else if (!v_quoted && (i_in.in_byte == CH_LF)) begin
                    // Unquoted newline: drop any held return, close the row.
                    n_qm = QM_UNQUOTED;
                    v_kind[v_cnt[0]] = KIND_ROW;
                    v_byte[v_cnt[0]] = 8'h00;
                    v_cnt  = v_cnt + 2'd1;
                    n_held = 1'b0;
                    n_fhc  = 1'b0;
                    n_rhf  = 1'b0;
                end else begin
                    // Content byte; a carriage return is held, not emitted.
                    if (!v_quoted) begin
                        n_qm = QM_UNQUOTED;
                    end
                    if (r_held) begin
                        v_kind[v_cnt[0]] = KIND_BYTE;
                        v_byte[v_cnt[0]] = CH_CR;
                        v_cnt = v_cnt + 2'd1;
                    end
                    if (i_in.in_byte == CH_CR) begin
                        n_held = 1'b1;
                    end else begin
                        v_kind[v_cnt[0]] = KIND_BYTE;
                        v_byte[v_cnt[0]] = i_in.in_byte;
                        v_cnt  = v_cnt + 2'd1;
                        n_held = 1'b0;
                    end
                    n_fhc = 1'b1;
                end
            end
        end
    end

    // Advance tokenizer state on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qm   <= QM_UNQUOTED;
            r_held <= 1'b0;
            r_fhc  <= 1'b0;
            r_rhf  <= 1'b0;
        end else if (in_fire) begin
            r_qm   <= n_qm;
            r_held <= n_held;
            r_fhc  <= n_fhc;
            r_rhf  <= n_rhf;
        end
    end

    // Result count and slot select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_sel <= 1'b0;
        end else if (in_fire) begin
            r_cnt <= v_cnt;
            r_sel <= 1'b0;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
            r_sel <= 1'b1;
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res[0].kind     <= v_kind[0];
            r_res[0].out_byte <= v_byte[0];
            r_res[0].last     <= (v_cnt == 2'd1);
            r_res[1].kind     <= v_kind[1];
            r_res[1].out_byte <= v_byte[1];
            r_res[1].last     <= 1'b1;
        end
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.kind     = r_res[r_sel].kind;
    assign o_out.out_byte = r_res[r_sel].out_byte;
    assign o_out.last     = r_res[r_sel].last;

    // Two results pending means the input must be held off.
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_in.ready)
        else $error("input taken while two results pending");

    // End of text leaves the tokenizer in its reset state.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.cmd == CMD_END)) |=>
            ((r_qm == QM_UNQUOTED) && !r_held && !r_fhc && !r_rhf))
        else $error("end of text did not reset state");

    // The second slot is only shown with a single result left, and it ends the beat.
    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_sel) |-> ((r_cnt == 2'd1) && o_out.last))
        else $error("second result slot out of order");

    // A held return never survives an unquoted newline.
    a_lf_drops_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.cmd == CMD_BYTE) && (i_in.in_byte == CH_LF)
            && (r_qm != QM_QUOTED)) |=> !r_held)
        else $error("held return kept past a row end");

endmodule

`default_nettype wire
